FILE: hdl/rvm_pkg.sv
// Shared types, constants and opcodes for the register VM execute unit.
// No dependencies; every other file but rvm_dmem refers to this package by scoped names.
`default_nettype none
package rvm_pkg;

  localparam int NUM_REGS        = 256;
  localparam int DATA_BYTES_DEF  = 65536;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int MAX_BYTES       = 8;

  localparam logic [7:0] IDX_LR = 8'd253;
  localparam logic [7:0] IDX_SP = 8'd254;
  localparam logic [7:0] IDX_IP = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LENGTH    = 2'd2;

  typedef enum logic [4:0] {
    CMD_MOV_IMM  = 5'd0,  CMD_MOV_REG = 5'd1,  CMD_ADD     = 5'd2,  CMD_SUB    = 5'd3,
    CMD_MUL      = 5'd4,  CMD_DIV     = 5'd5,  CMD_EQ      = 5'd6,  CMD_LT     = 5'd7,
    CMD_LTE      = 5'd8,  CMD_GT      = 5'd9,  CMD_GTE     = 5'd10, CMD_JMP    = 5'd11,
    CMD_JMPIF    = 5'd12, CMD_JMPIFN  = 5'd13, CMD_CALL    = 5'd14, CMD_SYSCALL = 5'd15,
    CMD_HALT     = 5'd16, CMD_RET     = 5'd17, CMD_STORE8  = 5'd18, CMD_STORE16 = 5'd19,
    CMD_STORE32  = 5'd20, CMD_STORE64 = 5'd21, CMD_LOAD8   = 5'd22, CMD_LOAD16 = 5'd23,
    CMD_LOAD32   = 5'd24, CMD_LOAD64  = 5'd25, CMD_LOAD_STR = 5'd26, CMD_NATIVE = 5'd27
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HALTED      = 3'd1,
    ST_DIV_ZERO    = 3'd2,
    ST_BAD_ADDRESS = 3'd3,
    ST_BAD_POOL    = 3'd4,
    ST_BAD_SYSCALL = 3'd5,
    ST_NATIVE      = 3'd6,
    ST_IP_OUT      = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_EQ, ALU_LT, ALU_LTE, ALU_GT, ALU_GTE
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

endpackage
`default_nettype wire

FILE: hdl/rvm_ifs.sv
// Valid/ready channel interfaces: instruction items, result items, config writes.
// Depends on rvm_pkg for widths.
`default_nettype none
interface rvm_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic        dest_is_reg;
  logic [63:0] dest_value;
  logic        left_is_reg;
  logic [63:0] left_value;
  logic        right_is_reg;
  logic [63:0] right_value;
  modport source (output valid, cmd, dest_is_reg, dest_value, left_is_reg, left_value,
                  right_is_reg, right_value, input ready);
  modport sink   (input valid, cmd, dest_is_reg, dest_value, left_is_reg, left_value,
                  right_is_reg, right_value, output ready);
endinterface

interface rvm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_ip;
  logic [2:0]  status;
  logic        reg_written;
  logic [7:0]  written_index;
  logic [3:0]  written_bytes;
  logic [63:0] written_value;
  modport source (output valid, next_ip, status, reg_written, written_index, written_bytes,
                  written_value, input ready);
  modport sink   (input valid, next_ip, status, reg_written, written_index, written_bytes,
                  written_value, output ready);
endinterface

interface rvm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rvm_pkg::CFG_IDX_W-1:0]   index;
  logic [rvm_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/register_vm_execute_unit_top.sv
// Register VM execute unit: sequencer, ip register, config registers and outputs.
// Depends on rvm_pkg, rvm_ifs, rvm_regfile, rvm_dmem and rvm_alu.
//
// One instruction item is taken at a time; the block is not ready again until
// its result item has been taken. Operand reads go one at a time through the
// single registered read port of the register file; add, subtract, compares,
// multiply and divide go through the shared unit; stores move one byte per
// cycle and loads one byte per request and capture state through the single
// data memory port. After reset the data memory is cleared by a sweep, during
// which no item is taken; configuration writes are accepted at any time.
`default_nettype none
module register_vm_execute_unit_top #(
  parameter int DATA_BYTES = rvm_pkg::DATA_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rvm_in_if.sink       item_in,
  rvm_out_if.source    item_out,
  rvm_cfg_if.sink      cfg
);
  localparam int AW = $clog2(DATA_BYTES);
  localparam logic [63:0] MEM_SIZE = 64'(DATA_BYTES);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_RD_D    = 12'b0000_0000_0010,
    S_RD_L    = 12'b0000_0000_0100,
    S_RD_R    = 12'b0000_0000_1000,
    S_EXEC    = 12'b0000_0001_0000,
    S_ALU     = 12'b0000_0010_0000,
    S_MEM_REQ = 12'b0000_0100_0000,
    S_MEM_CAP = 12'b0000_1000_0000,
    S_WRITE   = 12'b0001_0000_0000,
    S_FIN     = 12'b0010_0000_0000,
    S_OUT     = 12'b0100_0000_0000,
    S_SPARE   = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [31:0] program_length;
  logic [15:0] pool_base;
  logic [15:0] pool_length;

  // item
  logic [4:0]  cmd_q;
  logic        dr_q, lr_q, rr_q;
  logic [63:0] dv_q, lv_q, rv_q;

  logic [63:0] ip;
  logic [63:0] d_raw, l_raw, r_q, val_q, addr_q;
  logic        rd_ip;
  logic        adv_q;
  logic [2:0]  k_q, last_q;
  logic [1:0]  sz;

  logic [2:0]  st_q;
  logic        wr_q;
  logic [7:0]  widx_q;
  logic [3:0]  wbytes_q;
  logic [63:0] wval_q;

  // register file ports
  logic        rf_we;
  logic [7:0]  rf_waddr, rf_raddr;
  logic [63:0] rf_wdata, rf_rdata;
  logic [63:0] rd_now;

  // data memory ports
  logic          dm_we, dm_busy;
  logic [AW-1:0] dm_addr;
  logic [7:0]    dm_wdata, dm_rdata;

  rvm_pkg::alu_req_t alu_req;
  logic        alu_done;
  logic [63:0] alu_res;

  logic [63:0] dop, lop, rop_now;
  logic        is_store, is_load, is_arith;
  logic [3:0]  nbytes;
  logic [63:0] mask, merged;
  logic        addr_bad;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= 32'd0;
      pool_base      <= 16'd0;
      pool_length    <= 16'd0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rvm_pkg::CFG_PROGRAM_LENGTH: program_length <= cfg.data;
        rvm_pkg::CFG_POOL_BASE:      pool_base      <= cfg.data[15:0];
        rvm_pkg::CFG_POOL_LENGTH:    pool_length    <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  rvm_regfile #(.SP_RESET(MEM_SIZE)) u_regfile (
    .clk, .rst, .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  rvm_dmem #(.DATA_BYTES(DATA_BYTES)) u_dmem (
    .clk, .rst, .we(dm_we), .addr(dm_addr), .wdata(dm_wdata),
    .rdata(dm_rdata), .busy(dm_busy)
  );

  rvm_alu u_alu (.clk, .rst, .req(alu_req), .done(alu_done), .res(alu_res));

  // r255 lives in the ip register, not in the file
  assign rd_now  = rd_ip ? ip : rf_rdata;
  assign dop     = dr_q ? d_raw : dv_q;
  assign lop     = lr_q ? l_raw : lv_q;
  assign rop_now = rr_q ? rd_now : rv_q;

  assign is_arith = (cmd_q >= rvm_pkg::CMD_ADD) && (cmd_q <= rvm_pkg::CMD_GTE);
  assign is_store = (cmd_q >= rvm_pkg::CMD_STORE8) && (cmd_q <= rvm_pkg::CMD_STORE64);
  assign is_load  = (cmd_q >= rvm_pkg::CMD_LOAD8) && (cmd_q <= rvm_pkg::CMD_LOAD64);
  assign sz       = is_store ? 2'(cmd_q - rvm_pkg::CMD_STORE8) : 2'(cmd_q - rvm_pkg::CMD_LOAD8);

  assign nbytes = (dv_q[15:8] > 8'd8) ? 4'd8 : dv_q[11:8];
  always_comb begin
    for (int j = 0; j < rvm_pkg::MAX_BYTES; j++) begin
      mask[8*j +: 8] = (4'(j) < nbytes) ? 8'hFF : 8'h00;
    end
  end
  assign merged = (d_raw & ~mask) | (val_q & mask);

  assign addr_bad = alu_res > (MEM_SIZE - (64'd1 << sz));

  always_comb begin
    rf_raddr = dv_q[7:0];
    unique case (state)
      S_RD_D:  rf_raddr = (cmd_q == rvm_pkg::CMD_RET) ? rvm_pkg::IDX_LR : dv_q[7:0];
      S_RD_L:  rf_raddr = lv_q[7:0];
      S_RD_R:  rf_raddr = rv_q[7:0];
      default: ;
    endcase
  end

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = dv_q[7:0];
    rf_wdata = merged;
    if (state == S_EXEC && cmd_q == rvm_pkg::CMD_CALL &&
        ip >= {32'd0, program_length} == 1'b0) begin
      rf_we    = 1'b1;
      rf_waddr = rvm_pkg::IDX_LR;
      rf_wdata = ip;
    end else if (state == S_WRITE && nbytes != 4'd0 && dv_q[7:0] != rvm_pkg::IDX_IP) begin
      rf_we = 1'b1;
    end
  end

  assign dm_we    = (state == S_MEM_REQ) && is_store;
  assign dm_addr  = addr_q[AW-1:0] + AW'(k_q);
  assign dm_wdata = r_q[8*k_q +: 8];

  always_comb begin
    alu_req       = '0;
    alu_req.op    = rvm_pkg::ALU_ADD;
    alu_req.a     = lop;
    alu_req.b     = rop_now;
    if (state == S_EXEC && ip < {32'd0, program_length}) begin
      if (is_arith) begin
        alu_req.start = dr_q && !(cmd_q == rvm_pkg::CMD_DIV && rop_now == 64'd0);
        case (cmd_q)
          rvm_pkg::CMD_ADD: alu_req.op = rvm_pkg::ALU_ADD;
          rvm_pkg::CMD_SUB: alu_req.op = rvm_pkg::ALU_SUB;
          rvm_pkg::CMD_MUL: alu_req.op = rvm_pkg::ALU_MUL;
          rvm_pkg::CMD_DIV: alu_req.op = rvm_pkg::ALU_DIV;
          rvm_pkg::CMD_EQ:  alu_req.op = rvm_pkg::ALU_EQ;
          rvm_pkg::CMD_LT:  alu_req.op = rvm_pkg::ALU_LT;
          rvm_pkg::CMD_LTE: alu_req.op = rvm_pkg::ALU_LTE;
          rvm_pkg::CMD_GT:  alu_req.op = rvm_pkg::ALU_GT;
          default:          alu_req.op = rvm_pkg::ALU_GTE;
        endcase
      end else if (is_store) begin
        alu_req.start = 1'b1;
        alu_req.a     = dop;
        alu_req.b     = lop << sz;
      end else if (is_load) begin
        alu_req.start = 1'b1;
        alu_req.b     = rop_now << sz;
      end else if (cmd_q == rvm_pkg::CMD_LOAD_STR) begin
        alu_req.start = (lv_q <= {48'd0, pool_length});
        alu_req.a     = {48'd0, pool_base};
        alu_req.b     = lv_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ip <= (rf_raddr == rvm_pkg::IDX_IP);
    if (rst) begin
      state <= S_IDLE;
      ip    <= 64'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_in.valid && item_in.ready) begin
            cmd_q    <= item_in.cmd;
            dr_q     <= item_in.dest_is_reg;
            dv_q     <= item_in.dest_value;
            lr_q     <= item_in.left_is_reg;
            lv_q     <= item_in.left_value;
            rr_q     <= item_in.right_is_reg;
            rv_q     <= item_in.right_value;
            st_q     <= rvm_pkg::ST_OK;
            wr_q     <= 1'b0;
            widx_q   <= 8'd0;
            wbytes_q <= 4'd0;
            wval_q   <= 64'd0;
            adv_q    <= 1'b1;
            state    <= S_RD_D;
          end
        end
        S_RD_D: state <= S_RD_L;
        S_RD_L: begin
          d_raw <= rd_now;
          state <= S_RD_R;
        end
        S_RD_R: begin
          l_raw <= rd_now;
          state <= S_EXEC;
        end
        S_EXEC: begin
          r_q   <= rop_now;
          state <= S_FIN;
          if (ip >= {32'd0, program_length}) begin
            st_q  <= rvm_pkg::ST_IP_OUT;
            adv_q <= 1'b0;
          end else begin
            unique case (cmd_q) inside
              rvm_pkg::CMD_MOV_IMM: begin
                val_q <= lv_q;
                state <= S_WRITE;
              end
              rvm_pkg::CMD_MOV_REG: begin
                val_q <= lop;
                state <= S_WRITE;
              end
              rvm_pkg::CMD_ADD, rvm_pkg::CMD_SUB, rvm_pkg::CMD_MUL, rvm_pkg::CMD_DIV,
              rvm_pkg::CMD_EQ, rvm_pkg::CMD_LT, rvm_pkg::CMD_LTE, rvm_pkg::CMD_GT,
              rvm_pkg::CMD_GTE: begin
                if (dr_q) begin
                  if (cmd_q == rvm_pkg::CMD_DIV && rop_now == 64'd0) begin
                    st_q  <= rvm_pkg::ST_DIV_ZERO;
                    adv_q <= 1'b0;
                  end else begin
                    state <= S_ALU;
                  end
                end
              end
              rvm_pkg::CMD_JMP: begin
                ip    <= dop;
                adv_q <= 1'b0;
              end
              rvm_pkg::CMD_JMPIF, rvm_pkg::CMD_JMPIFN: begin
                if ((cmd_q == rvm_pkg::CMD_JMPIF) == (dop != 64'd0)) begin
                  ip    <= lop;
                  adv_q <= 1'b0;
                end
              end
              rvm_pkg::CMD_CALL: begin
                wr_q     <= 1'b1;
                widx_q   <= rvm_pkg::IDX_LR;
                wbytes_q <= 4'd8;
                wval_q   <= ip;
                // the target is read after the link register takes the ip
                ip       <= (dr_q && dv_q[7:0] == rvm_pkg::IDX_LR) ? ip : dop;
                adv_q    <= 1'b0;
              end
              rvm_pkg::CMD_SYSCALL: begin
                if (dv_q != 64'd0) begin
                  st_q  <= rvm_pkg::ST_BAD_SYSCALL;
                  adv_q <= 1'b0;
                end
              end
              rvm_pkg::CMD_HALT: begin
                st_q  <= rvm_pkg::ST_HALTED;
                adv_q <= 1'b0;
              end
              rvm_pkg::CMD_RET: begin
                ip    <= d_raw + 64'd1;
                adv_q <= 1'b0;
              end
              rvm_pkg::CMD_STORE8, rvm_pkg::CMD_STORE16, rvm_pkg::CMD_STORE32,
              rvm_pkg::CMD_STORE64, rvm_pkg::CMD_LOAD8, rvm_pkg::CMD_LOAD16,
              rvm_pkg::CMD_LOAD32, rvm_pkg::CMD_LOAD64: begin
                state <= S_ALU;
              end
              rvm_pkg::CMD_LOAD_STR: begin
                if (lv_q > {48'd0, pool_length}) begin
                  st_q  <= rvm_pkg::ST_BAD_POOL;
                  adv_q <= 1'b0;
                end else begin
                  state <= S_ALU;
                end
              end
              rvm_pkg::CMD_NATIVE: begin
                st_q  <= rvm_pkg::ST_NATIVE;
                adv_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_ALU: begin
          if (alu_done) begin
            if (is_store || is_load) begin
              addr_q <= alu_res;
              k_q    <= 3'd0;
              last_q <= 3'((4'd1 << sz) - 4'd1);
              val_q  <= 64'd0;
              if (addr_bad) begin
                st_q  <= rvm_pkg::ST_BAD_ADDRESS;
                adv_q <= 1'b0;
                state <= S_FIN;
              end else begin
                state <= S_MEM_REQ;
              end
            end else begin
              val_q <= alu_res;
              state <= S_WRITE;
            end
          end
        end
        S_MEM_REQ: begin
          if (is_store) begin
            k_q <= k_q + 3'd1;
            if (k_q == last_q) begin
              state <= S_FIN;
            end
          end else begin
            state <= S_MEM_CAP;
          end
        end
        S_MEM_CAP: begin
          val_q[8*k_q +: 8] <= dm_rdata;
          k_q <= k_q + 3'd1;
          state <= (k_q == last_q) ? S_WRITE : S_MEM_REQ;
        end
        S_WRITE: begin
          if (nbytes != 4'd0) begin
            wr_q     <= 1'b1;
            widx_q   <= dv_q[7:0];
            wbytes_q <= nbytes;
            wval_q   <= merged;
            if (dv_q[7:0] == rvm_pkg::IDX_IP) begin
              ip <= merged;
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (adv_q) begin
            ip <= ip + 64'd1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (item_out.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item_in.ready          = (state == S_IDLE) && !dm_busy;
  assign item_out.valid         = (state == S_OUT);
  assign item_out.next_ip       = ip;
  assign item_out.status        = st_q;
  assign item_out.reg_written   = wr_q;
  assign item_out.written_index = widx_q;
  assign item_out.written_bytes = wbytes_q;
  assign item_out.written_value = wval_q;
endmodule
`default_nettype wire

FILE: hdl/rvm_regfile.sv
// 256 x 64 register file memory with one write and one registered read port.
// Per-entry valid bits give the reset contents. Depends on rvm_pkg.
`default_nettype none
module rvm_regfile #(
  parameter logic [63:0] SP_RESET = 64'd65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        we,
  input  logic [7:0]  waddr,
  input  logic [63:0] wdata,
  input  logic [7:0]  raddr,
  output logic [63:0] rdata
);
  logic [63:0] mem [rvm_pkg::NUM_REGS];
  logic [rvm_pkg::NUM_REGS-1:0] valid;
  logic [63:0] mem_q;
  logic        vld_q;
  logic        sp_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
      sp_q  <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      vld_q <= valid[raddr];
      sp_q  <= (raddr == rvm_pkg::IDX_SP);
    end
  end

  // never-written entries read as their reset value
  assign rdata = vld_q ? mem_q : (sp_q ? SP_RESET : 64'd0);
endmodule
`default_nettype wire

FILE: hdl/rvm_dmem.sv
// Byte-wide data memory, one port, registered read, cleared by a sweep after reset.
// Depends on nothing beyond its parameter.
`default_nettype none
module rvm_dmem #(
  parameter int DATA_BYTES = 65536,
  localparam int AW = $clog2(DATA_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata,
  output logic          busy
);
  logic [7:0]    mem [DATA_BYTES];
  logic [AW-1:0] clr_addr;
  logic          clearing;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DATA_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy = clearing;
endmodule
`default_nettype wire

FILE: hdl/rvm_alu.sv
// Shared 64-bit arithmetic unit around one adder: add, subtract, signed compares
// with registered results; shift-add multiply and signed restoring divide
// one bit a cycle. Depends on rvm_pkg.
`default_nettype none
module rvm_alu (
  input  logic              clk,
  input  logic              rst,
  input  rvm_pkg::alu_req_t req,
  output logic              done,
  output logic [63:0]       res
);
  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_MUL  = 6'b000010,
    A_NEGA = 6'b000100,
    A_NEGB = 6'b001000,
    A_DIV  = 6'b010000,
    A_NEGQ = 6'b100000
  } astate_t;

  localparam logic [63:0] MSB = 64'h8000_0000_0000_0000;

  astate_t     state;
  logic [63:0] x_q, y_q, acc;
  logic [5:0]  cnt;
  logic        neg_q;
  logic [63:0] ax, ay;
  logic        asub;
  logic [64:0] sum;
  logic        carry, eq, ltu;
  logic [63:0] r2;

  assign r2 = {acc[62:0], y_q[63]};

  always_comb begin
    ax   = 64'd0;
    ay   = 64'd0;
    asub = 1'b0;
    unique case (state)
      A_IDLE: begin
        ax = req.a;
        ay = req.b;
        case (req.op)
          rvm_pkg::ALU_ADD: asub = 1'b0;
          rvm_pkg::ALU_SUB: asub = 1'b1;
          default: begin
            // flip sign bits so an unsigned borrow gives the signed order
            ax   = req.a ^ MSB;
            ay   = req.b ^ MSB;
            asub = 1'b1;
          end
        endcase
      end
      A_MUL: begin
        ax = acc;
        ay = x_q;
      end
      A_NEGA: begin
        ay   = y_q;
        asub = 1'b1;
      end
      A_NEGB: begin
        ay   = x_q;
        asub = 1'b1;
      end
      A_DIV: begin
        ax   = r2;
        ay   = x_q;
        asub = 1'b1;
      end
      A_NEGQ: begin
        ay   = y_q;
        asub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum   = {1'b0, ax} + {1'b0, (asub ? ~ay : ay)} + {64'd0, asub};
  assign carry = sum[64];
  assign eq    = (sum[63:0] == 64'd0);
  assign ltu   = ~carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              rvm_pkg::ALU_ADD, rvm_pkg::ALU_SUB: begin
                res  <= sum[63:0];
                done <= 1'b1;
              end
              rvm_pkg::ALU_EQ:  begin res <= {63'd0, eq};         done <= 1'b1; end
              rvm_pkg::ALU_LT:  begin res <= {63'd0, ltu};        done <= 1'b1; end
              rvm_pkg::ALU_LTE: begin res <= {63'd0, ltu | eq};   done <= 1'b1; end
              rvm_pkg::ALU_GT:  begin res <= {63'd0, ~(ltu | eq)}; done <= 1'b1; end
              rvm_pkg::ALU_GTE: begin res <= {63'd0, ~ltu};       done <= 1'b1; end
              rvm_pkg::ALU_MUL: begin
                acc   <= 64'd0;
                x_q   <= req.a;
                y_q   <= req.b;
                cnt   <= 6'd0;
                state <= A_MUL;
              end
              default: begin
                x_q   <= req.b;
                y_q   <= req.a;
                neg_q <= req.a[63] ^ req.b[63];
                state <= A_NEGA;
              end
            endcase
          end
        end
        A_MUL: begin
          acc <= y_q[0] ? sum[63:0] : acc;
          x_q <= {x_q[62:0], 1'b0};
          y_q <= {1'b0, y_q[63:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            res   <= y_q[0] ? sum[63:0] : acc;
            done  <= 1'b1;
            state <= A_IDLE;
          end
        end
        A_NEGA: begin
          if (y_q[63]) begin
            y_q <= sum[63:0];
          end
          state <= A_NEGB;
        end
        A_NEGB: begin
          if (x_q[63]) begin
            x_q <= sum[63:0];
          end
          acc   <= 64'd0;
          cnt   <= 6'd0;
          state <= A_DIV;
        end
        A_DIV: begin
          acc <= carry ? sum[63:0] : r2;
          y_q <= {y_q[62:0], carry};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= A_NEGQ;
          end
        end
        A_NEGQ: begin
          res   <= neg_q ? sum[63:0] : y_q;
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/rvm_checker.sv
// Port-level assertions for the register VM execute unit, bound to the top level.
// Depends on rvm_pkg and the top level's interface ports.
`default_nettype none
module rvm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic [2:0]  status,
  input logic        reg_written,
  input logic [7:0]  written_index,
  input logic [3:0]  written_bytes,
  input logic [63:0] written_value
);
  // memory clear follows every reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("item taken during memory clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("new item taken while a result is pending");

  a_error_no_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != rvm_pkg::ST_OK) |-> !reg_written)
    else $error("register written on a failed instruction");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reg_written) |->
      (written_index == 8'd0 && written_bytes == 4'd0 && written_value == 64'd0))
    else $error("write fields set without a write");

  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reg_written) |-> (written_bytes != 4'd0 && written_bytes <= 4'd8))
    else $error("byte count out of range");
endmodule

bind register_vm_execute_unit_top rvm_checker u_checker (
  .clk(clk), .rst(rst),
  .in_ready(item_in.ready),
  .out_valid(item_out.valid), .status(item_out.status),
  .reg_written(item_out.reg_written), .written_index(item_out.written_index),
  .written_bytes(item_out.written_bytes), .written_value(item_out.written_value)
);
`default_nettype wire
